// File: rtl/core/qs_pkg.sv
// ----------------------------------------------------------------------------
// qs_pkg: shared types and constants for the quicksort block
// sequencer state encoding, data width and default store depth
// ----------------------------------------------------------------------------
package qs_pkg;

  localparam int VALUE_W       = 32;
  localparam int DEF_MAX_ELEMS = 64;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_POP,
    S_POP_WAIT,
    S_PIV_WAIT,
    S_LSCAN,
    S_LCMP,
    S_RSCAN,
    S_RCMP,
    S_SWAP1,
    S_SWAP2,
    S_FIN1,
    S_FIN2,
    S_PUSH_HI,
    S_PUSH_LO,
    S_OUT
  } state_t;

endpackage

// File: rtl/core/quicksort_first_pivot.sv
// ----------------------------------------------------------------------------
// quicksort_first_pivot: load, sort and replay a set of signed values
// quicksort with first-element pivot, two-index partition and a range stack
// ----------------------------------------------------------------------------
//
// channel   signals                             handshake
// -------   ---------------------------------   ------------------------------
// input     value, last_item                    taken when start && !busy
// result    sorted_value, last_result           valid while strobe is high
//
// - a non-last item is stored and busy stays low
// - an item with last_item set starts the sort: each compare is a store read,
//   then a compare against the pivot; each swap is two writes; each popped
//   range adds its pop, pivot read, pivot placement and push steps; n log n
//   to n^2 compares; the sorted run comes out one item per cycle, n items,
//   then busy drops; items beyond MAX_ELEMS are dropped; a last item still
//   starts the sort; rst is synchronous; the rams need no clearing pass
// - the receiver cannot stall: each result shows for exactly one cycle
//
module quicksort_first_pivot #(
  parameter int MAX_ELEMS = qs_pkg::DEF_MAX_ELEMS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [qs_pkg::VALUE_W-1:0]  value,
  input  logic                               last_item,
  output logic                               strobe,
  output logic signed [qs_pkg::VALUE_W-1:0]  sorted_value,
  output logic                               last_result
);

  import qs_pkg::*;

  // index, count and stack entry widths follow the store depth
  localparam int AW      = $clog2(MAX_ELEMS);
  localparam int CW      = $clog2(MAX_ELEMS + 1);
  localparam int SEW     = 2 * AW;
  localparam int SP_MAX  = MAX_ELEMS / 2;

  state_t state, state_next;

  logic [CW-1:0]      count, count_next;
  logic [CW-1:0]      sp, sp_next;
  logic [AW-1:0]      lo, lo_next;
  logic [AW-1:0]      hi, hi_next;
  logic [AW-1:0]      l, l_next;
  logic [AW-1:0]      r, r_next;
  logic [AW-1:0]      k, k_next;
  logic [VALUE_W-1:0] pivot, pivot_next;
  logic [VALUE_W-1:0] vl, vl_next;
  logic [VALUE_W-1:0] vr, vr_next;
  logic               strobe_next;
  logic               last_next;

  // element store ports
  logic               st_we, st_re;
  logic [AW-1:0]      st_waddr, st_raddr;
  logic [VALUE_W-1:0] st_wdata, st_rdata;

  // range stack ports
  logic               sk_we, sk_re;
  logic [AW-1:0]      sk_waddr, sk_raddr;
  logic [SEW-1:0]     sk_wdata, sk_rdata;

  // popped range fields
  logic [AW-1:0]      pop_lo, pop_hi;

  // the one shared compare: store word against the pivot, signed order
  logic               le_pivot;

  assign pop_lo   = sk_rdata[AW-1:0];
  assign pop_hi   = sk_rdata[SEW-1:AW];
  assign le_pivot = $signed(st_rdata) <= $signed(pivot);

  assign busy         = (state != S_IDLE);
  assign sorted_value = $signed(st_rdata);

  qs_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (MAX_ELEMS)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  qs_ram #(
    .WIDTH (SEW),
    .DEPTH (MAX_ELEMS)
  ) u_stack (
    .clk   (clk),
    .we    (sk_we),
    .waddr (sk_waddr),
    .wdata (sk_wdata),
    .re    (sk_re),
    .raddr (sk_raddr),
    .rdata (sk_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      count       <= '0;
      sp          <= '0;
      strobe      <= 1'b0;
      last_result <= 1'b0;
    end else begin
      state       <= state_next;
      count       <= count_next;
      sp          <= sp_next;
      strobe      <= strobe_next;
      last_result <= last_next;
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    lo    <= lo_next;
    hi    <= hi_next;
    l     <= l_next;
    r     <= r_next;
    k     <= k_next;
    pivot <= pivot_next;
    vl    <= vl_next;
    vr    <= vr_next;
  end

  always_comb begin
    state_next  = state;
    count_next  = count;
    sp_next     = sp;
    lo_next     = lo;
    hi_next     = hi;
    l_next      = l;
    r_next      = r;
    k_next      = k;
    pivot_next  = pivot;
    vl_next     = vl;
    vr_next     = vr;
    strobe_next = 1'b0;
    last_next   = 1'b0;

    st_we    = 1'b0;
    st_waddr = '0;
    st_wdata = '0;
    st_re    = 1'b0;
    st_raddr = '0;
    sk_we    = 1'b0;
    sk_waddr = '0;
    sk_wdata = '0;
    sk_re    = 1'b0;
    sk_raddr = '0;

    case (state)
      S_IDLE: begin
        if (start) begin
          // store the item unless the set is already full
          if (count < CW'(MAX_ELEMS)) begin
            st_we      = 1'b1;
            st_waddr   = count[AW-1:0];
            st_wdata   = value;
            count_next = count + 1'b1;
          end
          if (last_item) begin
            state_next = S_INIT;
          end
        end
      end

      S_INIT: begin
        // whole set is the first range; a single item needs no sort
        k_next = '0;
        if (count >= CW'(2)) begin
          sk_we      = 1'b1;
          sk_waddr   = '0;
          sk_wdata   = {AW'(count - 1'b1), AW'(0)};
          sp_next    = CW'(1);
          state_next = S_POP;
        end else begin
          state_next = S_OUT;
        end
      end

      S_POP: begin
        if (sp == '0) begin
          k_next     = '0;
          state_next = S_OUT;
        end else begin
          sk_re      = 1'b1;
          sk_raddr   = AW'(sp - 1'b1);
          sp_next    = sp - 1'b1;
          state_next = S_POP_WAIT;
        end
      end

      S_POP_WAIT: begin
        if (pop_hi <= pop_lo) begin
          state_next = S_POP;
        end else begin
          lo_next    = pop_lo;
          hi_next    = pop_hi;
          l_next     = pop_lo;
          r_next     = pop_hi;
          st_re      = 1'b1;
          st_raddr   = pop_lo;
          state_next = S_PIV_WAIT;
        end
      end

      S_PIV_WAIT: begin
        pivot_next = st_rdata;
        state_next = S_LSCAN;
      end

      // left scan: advance while the word is not above the pivot
      S_LSCAN: begin
        if (l < hi) begin
          st_re      = 1'b1;
          st_raddr   = l;
          state_next = S_LCMP;
        end else begin
          state_next = S_RSCAN;
        end
      end

      S_LCMP: begin
        vl_next = st_rdata;
        if (le_pivot) begin
          l_next     = l + 1'b1;
          state_next = S_LSCAN;
        end else begin
          state_next = S_RSCAN;
        end
      end

      // right scan: retreat while the word is above the pivot
      S_RSCAN: begin
        if (r > lo) begin
          st_re      = 1'b1;
          st_raddr   = r;
          state_next = S_RCMP;
        end else begin
          state_next = S_SWAP1;
        end
      end

      S_RCMP: begin
        vr_next = st_rdata;
        if (!le_pivot) begin
          r_next     = r - 1'b1;
          state_next = S_RSCAN;
        end else begin
          state_next = S_SWAP1;
        end
      end

      S_SWAP1: begin
        if (l < r) begin
          st_we      = 1'b1;
          st_waddr   = l;
          st_wdata   = vr;
          state_next = S_SWAP2;
        end else begin
          state_next = S_FIN1;
        end
      end

      S_SWAP2: begin
        st_we      = 1'b1;
        st_waddr   = r;
        st_wdata   = vl;
        state_next = S_LSCAN;
      end

      // pivot into place; when r stayed at lo the second write wins
      S_FIN1: begin
        st_we      = 1'b1;
        st_waddr   = lo;
        st_wdata   = vr;
        state_next = S_FIN2;
      end

      S_FIN2: begin
        st_we      = 1'b1;
        st_waddr   = r;
        st_wdata   = pivot;
        state_next = S_PUSH_HI;
      end

      S_PUSH_HI: begin
        if ({1'b0, hi} > ({1'b0, r} + 1'b1)) begin
          sk_we    = 1'b1;
          sk_waddr = sp[AW-1:0];
          sk_wdata = {hi, AW'(r + 1'b1)};
          sp_next  = sp + 1'b1;
        end
        state_next = S_PUSH_LO;
      end

      S_PUSH_LO: begin
        if ({1'b0, r} > ({1'b0, lo} + 1'b1)) begin
          sk_we    = 1'b1;
          sk_waddr = sp[AW-1:0];
          sk_wdata = {AW'(r - 1'b1), lo};
          sp_next  = sp + 1'b1;
        end
        state_next = S_POP;
      end

      // replay: read address k now, data and strobe follow in the next cycle
      S_OUT: begin
        st_re       = 1'b1;
        st_raddr    = k;
        strobe_next = 1'b1;
        k_next      = k + 1'b1;
        if ({1'b0, k} == (count - 1'b1)) begin
          last_next  = 1'b1;
          count_next = '0;
          sp_next    = '0;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // a result only follows a replay read
  a_strobe_after_out: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(state) == S_OUT)
    else $error("result strobe without a replay read");

  // pending ranges are disjoint and hold two or more items each
  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= CW'(SP_MAX))
    else $error("range stack deeper than half the store");

  // scan indexes stay inside the current range
  a_scan_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == S_LCMP || state == S_RCMP) |-> (l <= hi && r >= lo))
    else $error("scan index left its range");

  // the final mark comes with a strobe and ends the run
  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    last_result |-> (strobe && state == S_IDLE && count == '0))
    else $error("final mark outside the end of a run");

endmodule

// File: rtl/core/qs_ram.sv
// ----------------------------------------------------------------------------
// qs_ram: generic simple dual-port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module qs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
